// ===== rtl/lwsl_pkg.sv =====
// ----------------------------------------------------------------------------
// lwsl_pkg
// Shared widths, defaults and the result record of the longest window unit.
// ----------------------------------------------------------------------------
package lwsl_pkg;

	localparam int ELEM_W        = 16;
	localparam int VALUE_MAX_W   = 32;
	localparam int LIMIT_W       = 32;
	localparam int SUM_W         = 33;
	localparam int LEN_OUT_W     = 11;

	localparam int DEF_WINDOW_DEPTH = 1024;
	localparam int DEF_VALUE_BITS   = 16;

	typedef struct packed {
		logic [LEN_OUT_W-1:0] window_length;
		logic [LEN_OUT_W-1:0] best_length;
		logic                 window_overflow;
		logic                 sequence_done;
	} lwsl_result_t;

endpackage

// ===== rtl/lwsl_if.sv =====
// ----------------------------------------------------------------------------
// lwsl_if
// Valid/ready channels for element requests and result requests.
// ----------------------------------------------------------------------------
interface lwsl_sample_if import lwsl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ELEM_W-1:0] element_value;
	logic              end_of_sequence;

	modport source (output valid, element_value, end_of_sequence, input ready);
	modport sink (input valid, element_value, end_of_sequence, output ready);
endinterface

interface lwsl_result_if import lwsl_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [LEN_OUT_W-1:0] window_length;
	logic [LEN_OUT_W-1:0] best_length;
	logic                 window_overflow;
	logic                 sequence_done;

	modport source (output valid, window_length, best_length, window_overflow,
		sequence_done, input ready);
	modport sink (input valid, window_length, best_length, window_overflow,
		sequence_done, output ready);
endinterface

// ===== rtl/lwsl_store.sv =====
// ----------------------------------------------------------------------------
// lwsl_store
// Window element memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lwsl_store #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/lwsl_ctrl.sv =====
// ----------------------------------------------------------------------------
// lwsl_ctrl
// Two-pointer sequencer: adds each element, drops the oldest from the store
// one per cycle while over the limit, then appends the element unless it alone exceeds the limit, and reports.
// ----------------------------------------------------------------------------
module lwsl_ctrl import lwsl_pkg::*; #(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
	parameter int VALUE_BITS   = DEF_VALUE_BITS,
	parameter int AW           = $clog2(WINDOW_DEPTH),
	parameter int LW           = $clog2(WINDOW_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [LIMIT_W-1:0]    sum_limit,
	lwsl_sample_if.sink           sample,
	input  logic                  out_free,
	output logic                  res_valid,
	output lwsl_result_t          res,
	output logic                  mem_wr_en,
	output logic [AW-1:0]         mem_wr_addr,
	output logic [VALUE_BITS-1:0] mem_wr_data,
	output logic [AW-1:0]         mem_rd_addr,
	input  logic [VALUE_BITS-1:0] mem_rd_data
);

	typedef enum logic [0:0] {ST_IDLE, ST_CHECK} state_t;

	state_t                state_q;
	logic [SUM_W-1:0]      sum_q;
	logic [AW-1:0]         head_q;
	logic [AW-1:0]         tail_q;
	logic [LW-1:0]         len_q;
	logic [LW-1:0]         best_q;
	logic [VALUE_BITS-1:0] val_q;
	logic                  last_q;

	logic [VALUE_BITS-1:0] val_in;
	logic                  accept;
	logic                  over;
	logic                  drop_lim;
	logic                  fin;
	logic                  keep;
	logic                  full;
	logic [AW-1:0]         tail_adv;
	logic [AW-1:0]         head_adv;
	logic [LW-1:0]         new_len;
	logic [LW-1:0]         new_best;
	logic [SUM_W-1:0]      new_sum;

	assign val_in   = VALUE_BITS'({{(VALUE_MAX_W - ELEM_W){1'b0}}, sample.element_value});
	assign sample.ready = (state_q == ST_IDLE);
	assign accept   = sample.valid && sample.ready;

	assign over     = sum_q > SUM_W'(sum_limit);
	assign drop_lim = (state_q == ST_CHECK) && over && (len_q != '0);
	assign fin      = (state_q == ST_CHECK) && !drop_lim && out_free;
	// after the drop loop, still over means the element alone exceeds the limit
	assign keep     = !over;
	assign full     = (len_q == LW'(WINDOW_DEPTH));

	assign tail_adv = (tail_q == AW'(WINDOW_DEPTH - 1)) ? '0 : tail_q + AW'(1);
	assign head_adv = (head_q == AW'(WINDOW_DEPTH - 1)) ? '0 : head_q + AW'(1);

	always_comb begin
		if (!keep) begin
			new_len = '0;
			new_sum = '0;
		end else if (full) begin
			new_len = len_q;
			new_sum = sum_q - SUM_W'(mem_rd_data);
		end else begin
			new_len = len_q + LW'(1);
			new_sum = sum_q;
		end
		new_best = (new_len > best_q) ? new_len : best_q;
	end

	// read data always tracks the tail entry while checking
	assign mem_rd_addr = drop_lim ? tail_adv : tail_q;
	assign mem_wr_en   = fin && keep;
	assign mem_wr_addr = head_q;
	assign mem_wr_data = val_q;

	assign res_valid           = fin;
	assign res.window_length   = LEN_OUT_W'(new_len);
	assign res.best_length     = LEN_OUT_W'(new_best);
	assign res.window_overflow = keep && full;
	assign res.sequence_done   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q   <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			len_q   <= '0;
			best_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sum_q   <= sum_q + SUM_W'(val_in);
						last_q  <= sample.end_of_sequence;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (drop_lim) begin
						sum_q  <= sum_q - SUM_W'(mem_rd_data);
						tail_q <= tail_adv;
						len_q  <= len_q - LW'(1);
					end else if (fin) begin
						state_q <= ST_IDLE;
						if (last_q) begin
							sum_q  <= '0;
							head_q <= '0;
							tail_q <= '0;
							len_q  <= '0;
							best_q <= '0;
						end else begin
							sum_q  <= new_sum;
							len_q  <= new_len;
							best_q <= new_best;
							head_q <= keep ? head_adv : '0;
							if (!keep) begin
								tail_q <= '0;
							end else if (full) begin
								tail_q <= tail_adv;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= val_in;
		end
	end

`ifndef NO_ASSERTIONS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(WINDOW_DEPTH))
		else $error("window length beyond store depth");

	a_best_ge_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (best_q >= len_q))
		else $error("best length below current window");

	a_empty_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && len_q == '0) |-> (sum_q == '0 && head_q == tail_q))
		else $error("empty window with stale sum or pointers");

	a_seq_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && last_q) |=> (len_q == '0 && best_q == '0 && sum_q == '0))
		else $error("state not cleared after end of sequence");
`endif

endmodule

// ===== rtl/longest_window_sum_within_limit_unit.sv =====
// ----------------------------------------------------------------------------
// longest_window_sum_within_limit_unit
// Longest run of recent elements whose sum stays within a limit.
// ----------------------------------------------------------------------------
// Each element request is accepted only while idle, then checked, with one drop
// step for every element dropped from the window to get back under sum_limit;
// every element is dropped at most once. The drop rate is set by the single
// read port of the window store (one tail entry per cycle). A finished result
// sits in an output register, so the next element is taken while it waits; a
// result is held back only if the previous one has not been taken yet. The
// store needs no clearing after reset. The user must write sum_limit only
// while the unit is idle; the unit itself does not enforce this.
module longest_window_sum_within_limit_unit import lwsl_pkg::*; #(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
	parameter int VALUE_BITS   = DEF_VALUE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [LIMIT_W-1:0] cfg_write_data,
	lwsl_sample_if.sink        sample,
	lwsl_result_if.source      result
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int LW = $clog2(WINDOW_DEPTH + 1);

	logic [LIMIT_W-1:0]    limit_q;
	logic                  out_valid_q;
	lwsl_result_t          out_q;

	logic                  out_free;
	logic                  res_valid;
	lwsl_result_t          res;
	logic                  mem_wr_en;
	logic [AW-1:0]         mem_wr_addr;
	logic [VALUE_BITS-1:0] mem_wr_data;
	logic [AW-1:0]         mem_rd_addr;
	logic [VALUE_BITS-1:0] mem_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_write_en) begin
			limit_q <= cfg_write_data;
		end
	end

	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.window_length   = out_q.window_length;
	assign result.best_length     = out_q.best_length;
	assign result.window_overflow = out_q.window_overflow;
	assign result.sequence_done   = out_q.sequence_done;

	lwsl_ctrl #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.VALUE_BITS   (VALUE_BITS),
		.AW           (AW),
		.LW           (LW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.sum_limit   (limit_q),
		.sample      (sample),
		.out_free    (out_free),
		.res_valid   (res_valid),
		.res         (res),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	lwsl_store #(
		.DEPTH (WINDOW_DEPTH),
		.WIDTH (VALUE_BITS),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

endmodule

// ===== tb/lwsl_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lwsl_checker
// Watches the element and result channels and the limit register port. It
// keeps its own copy of the sliding window and predicts each result request.
// Each result is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module lwsl_checker import lwsl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write_en,
	input  logic [LIMIT_W-1:0] cfg_write_data,
	lwsl_sample_if             sample,
	lwsl_result_if             result,
	output int unsigned        fail_count,
	output int unsigned        pending,
	output int unsigned        result_count,
	output int unsigned        overflow_count,
	output int unsigned        done_count,
	output int unsigned        empty_count
);

	localparam int DEPTH = DEF_WINDOW_DEPTH;
	localparam int IDX_W = $clog2(DEPTH);

	logic [ELEM_W-1:0]    win_mem [DEPTH];
	logic [SUM_W-1:0]     win_sum;
	logic [IDX_W-1:0]     head_ptr;
	logic [IDX_W-1:0]     tail_ptr;
	logic [LEN_OUT_W-1:0] win_len;
	logic [LEN_OUT_W-1:0] best_len;
	logic [LIMIT_W-1:0]   sum_limit;

	lwsl_result_t window_results_q[$];

	task automatic drop_oldest();
		win_sum  = win_sum - SUM_W'(win_mem[tail_ptr]);
		tail_ptr = tail_ptr + 1'b1;
		win_len  = win_len - 1'b1;
	endtask

	task automatic clear_window();
		win_sum  = '0;
		head_ptr = '0;
		tail_ptr = '0;
		win_len  = '0;
		best_len = '0;
	endtask

	task automatic predict_window(input logic [ELEM_W-1:0] v, input logic last,
		output lwsl_result_t r);
		logic ovf;
		ovf = 1'b0;
		win_sum = win_sum + SUM_W'(v);
		while (win_sum > SUM_W'(sum_limit) && win_len != 0)
			drop_oldest();
		if (win_sum > SUM_W'(sum_limit)) begin
			// element alone is over the limit: not kept
			win_sum  = '0;
			head_ptr = '0;
			tail_ptr = '0;
		end else begin
			if (win_len >= LEN_OUT_W'(DEPTH)) begin
				drop_oldest();
				ovf = 1'b1;
			end
			win_mem[head_ptr] = v;
			head_ptr = head_ptr + 1'b1;
			win_len  = win_len + 1'b1;
		end
		if (win_len > best_len)
			best_len = win_len;
		r.window_length   = win_len;
		r.best_length     = best_len;
		r.window_overflow = ovf;
		r.sequence_done   = last;
		if (last)
			clear_window();
	endtask

	task automatic check_field(input string name, input logic [LEN_OUT_W-1:0] exp_v,
		input logic [LEN_OUT_W-1:0] got_v);
		if (got_v !== exp_v) begin
			fail_count++;
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		lwsl_result_t want;
		lwsl_result_t got;
		if (!arst_n) begin
			clear_window();
			sum_limit = '0;
			window_results_q.delete();
			fail_count     = 0;
			pending        = 0;
			result_count   = 0;
			overflow_count = 0;
			done_count     = 0;
			empty_count    = 0;
		end else begin
			if (cfg_write_en)
				sum_limit = cfg_write_data;
			if (sample.valid && sample.ready) begin
				predict_window(sample.element_value, sample.end_of_sequence, want);
				window_results_q.push_back(want);
			end
			if (result.valid && result.ready) begin
				got.window_length   = result.window_length;
				got.best_length     = result.best_length;
				got.window_overflow = result.window_overflow;
				got.sequence_done   = result.sequence_done;
				result_count++;
				if (window_results_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result: expected none, got %p", $time, got);
				end else begin
					want = window_results_q.pop_front();
					check_field("window_length", want.window_length, got.window_length);
					check_field("best_length", want.best_length, got.best_length);
					check_field("window_overflow", LEN_OUT_W'(want.window_overflow),
						LEN_OUT_W'(got.window_overflow));
					check_field("sequence_done", LEN_OUT_W'(want.sequence_done),
						LEN_OUT_W'(got.sequence_done));
					if (want.window_overflow)
						overflow_count++;
					if (want.sequence_done)
						done_count++;
					if (want.window_length == 0)
						empty_count++;
				end
			end
			pending = window_results_q.size();
		end
	end

endmodule

// ===== tb/tb_longest_window_sum_within_limit_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_longest_window_sum_within_limit_unit
// Drives element requests under several sum limits, with random gaps and
// result stalls, and leaves prediction and comparison to lwsl_checker.
// ----------------------------------------------------------------------------
module tb_longest_window_sum_within_limit_unit;
	import lwsl_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASE_ITEMS    = 19;
	localparam int FREE_RUN_ITEMS = 60;
	localparam int CAPACITY_ITEMS = 1100;

	logic               clk;
	logic               arst_n;
	logic               cfg_write_en;
	logic [LIMIT_W-1:0] cfg_write_data;

	lwsl_sample_if sample();
	lwsl_result_if result();

	int unsigned fail_count;
	int unsigned pending;
	int unsigned result_count;
	int unsigned overflow_count;
	int unsigned done_count;
	int unsigned empty_count;

	bit                 src_idle_en;
	bit                 snk_idle_en;
	bit                 hold_req;
	int unsigned        stall_left;
	int unsigned        sent_total;
	int unsigned        limit_writes;
	logic [LIMIT_W-1:0] cur_limit;

	longest_window_sum_within_limit_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.sample         (sample),
		.result         (result)
	);

	lwsl_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.sample         (sample),
		.result         (result),
		.fail_count     (fail_count),
		.pending        (pending),
		.result_count   (result_count),
		.overflow_count (overflow_count),
		.done_count     (done_count),
		.empty_count    (empty_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin
		result.ready = 1'b0;
		stall_left   = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				stall_left = HOLD_CYCLES;
				hold_req   = 1'b0;
			end
			if (stall_left != 0) begin
				stall_left--;
				result.ready <= 1'b0;
			end else if (snk_idle_en) begin
				result.ready <= ($urandom_range(99) >= 30);
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample.valid && sample.ready) || (result.valid && result.ready))
				quiet = 0;
			else if (arst_n)
				quiet++;
		end
		$display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("longest_window_sum_within_limit_unit test failed");
		$finish;
	end

	// values scaled to the limit so that windows both grow and shrink
	function automatic logic [ELEM_W-1:0] pick_element(input logic [LIMIT_W-1:0] lim);
		int unsigned r;
		int unsigned span;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		if (r < 15)
			return ELEM_W'(1);
		if (r < 35)
			return ELEM_W'($urandom_range(65535));
		span = lim / $urandom_range(2, 8);
		if (span > 65535)
			span = 65535;
		if (span == 0)
			span = 1;
		return ELEM_W'($urandom_range(1, span));
	endfunction

	task automatic send_element(input logic [ELEM_W-1:0] v, input logic last);
		while (src_idle_en && $urandom_range(99) < 30) begin
			sample.valid <= 1'b0;
			@(negedge clk);
		end
		sample.valid           <= 1'b1;
		sample.element_value   <= v;
		sample.end_of_sequence <= last;
		@(posedge clk);
		while (!sample.ready)
			@(posedge clk);
		@(negedge clk);
		sent_total++;
	endtask

	// sender pause until every result request has come back
	task automatic wait_idle();
		sample.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] val);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= val;
		@(negedge clk);
		cfg_write_en   <= 1'b0;
		@(negedge clk);
		cur_limit = val;
		limit_writes++;
	endtask

	initial begin
		int unsigned        n;
		int unsigned        seq_len;
		int unsigned        target;
		bit                 leave_open;
		logic [LIMIT_W-1:0] lim;

		arst_n                 = 1'b0;
		cfg_write_en           = 1'b0;
		cfg_write_data         = '0;
		sample.valid           = 1'b0;
		sample.element_value   = '0;
		sample.end_of_sequence = 1'b0;
		src_idle_en            = 1'b1;
		snk_idle_en            = 1'b1;
		hold_req               = 1'b0;
		sent_total             = 0;
		limit_writes           = 0;
		cur_limit              = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: drops, zero elements, oversize elements, sequence ends
		write_limit(32'd70000);
		send_element(16'd1, 1'b0);
		send_element(16'hFFFF, 1'b0);
		send_element(16'hFFFF, 1'b0);
		send_element(16'h0000, 1'b0);
		send_element(16'hAAAA, 1'b0);
		send_element(16'h5555, 1'b1);
		wait_idle();
		write_limit(32'd0);
		send_element(16'd5, 1'b0);
		send_element(16'h0000, 1'b0);
		send_element(16'h0000, 1'b0);
		send_element(16'h8000, 1'b0);
		send_element(16'h0000, 1'b1);
		wait_idle();
		write_limit(32'hFFFF_FFFF);
		send_element(16'hFFFF, 1'b0);
		send_element(16'hFFFF, 1'b0);
		send_element(16'd1, 1'b0);
		send_element(16'h7FFF, 1'b0);
		send_element(16'hFFFF, 1'b1);
		wait_idle();
		write_limit(32'd65535);
		send_element(16'hFFFF, 1'b0);
		send_element(16'd1, 1'b0);
		send_element(16'hFFFE, 1'b1);

		for (int ph = 0; ph < 11; ph++) begin
			wait_idle();
			case (ph)
				0: lim = '0;
				1: lim = '1;
				2: lim = 32'd65535;
				3: lim = 32'd65536;
				5: lim = '1;
				6, 8: lim = $urandom_range(1, 400000);
				7, 9: lim = $urandom;
				default: lim = $urandom_range(1000, 200000);
			endcase
			write_limit(lim);
			// phase 4 runs with no gaps on either side
			src_idle_en = (ph != 4);
			snk_idle_en = (ph != 4);
			if (ph == 2 || ph == 7)
				hold_req = 1'b1;
			if (ph == 5) begin
				// one long sequence runs the window past the buffer depth
				for (int i = 0; i < CAPACITY_ITEMS; i++)
					send_element(ELEM_W'($urandom_range(65535)), i == CAPACITY_ITEMS - 1);
			end else begin
				target     = (ph == 4) ? FREE_RUN_ITEMS : PHASE_ITEMS;
				leave_open = ($urandom_range(3) == 0);
				n = 0;
				while (n < target) begin
					if ($urandom_range(9) == 0)
						seq_len = $urandom_range(40, 200);
					else
						seq_len = $urandom_range(1, 25);
					if (seq_len > target - n)
						seq_len = target - n;
					for (int i = 0; i < seq_len; i++)
						send_element(pick_element(cur_limit),
							(i == seq_len - 1) && !(leave_open && n + seq_len == target));
					n += seq_len;
				end
			end
		end

		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
		wait_idle();
		repeat (20) @(negedge clk);

		$display("Sent %0d element requests under %0d sum limit settings; %0d results checked.",
			sent_total, limit_writes, result_count);
		$display("%0d capped windows, %0d closed sequences, %0d empty windows seen.",
			overflow_count, done_count, empty_count);
		if (fail_count == 0)
			$display("longest_window_sum_within_limit_unit test passed");
		else
			$display("longest_window_sum_within_limit_unit test failed");
		$finish;
	end

endmodule
